>>> design/assert_macros.svh
// Assertion macros used by the top level to check the blur datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// Checks that a cause implies an effect in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cause) |-> (effect)) \
        else $error("assertion failed");

`endif

>>> design/bb3_pkg.sv
// Shared constants and types of the 3x3 box blur stream unit.
package bb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 16;
    localparam int EW_W      = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ?
                               $clog2(MAX_WIDTH + 1) : WIDTH_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int SUM_W     = 12;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    // Register indexes of the configuration port.
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // Item kinds carried in tuser.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // Reciprocals for the divide by 6 and by 9, scaled by 2^16.
    localparam logic [13:0] RECIP6 = 14'd10923;
    localparam logic [13:0] RECIP9 = 14'd7282;

    typedef enum logic [1:0] {
        DIV4,
        DIV6,
        DIV9
    } div_sel_t;

    // One window column with the emit controls that go with it.
    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
        logic       emit;
        logic       top_ok;
        logic       bot_ok;
        logic       left_ok;
        logic       right_ok;
        logic       last;
    } win_col_t;

endpackage

>>> design/bb3_front.sv
// Front end: configuration, position tracking, line store and column fetch.
module bb3_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [15:0]                cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,
    input  logic                       s_tuser,
    input  logic [bb3_pkg::QCNT_W-1:0] q_count,
    output logic                       q_push,
    output bb3_pkg::win_col_t          q_entry
);
    import bb3_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [EW_W-1:0]     eff_w;
    logic [HEIGHT_W-1:0] eff_h;

    logic [HEIGHT_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [HEIGHT_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic                draining_reg, draining_next;
    logic [EW_W-1:0]     drain_col_reg, drain_col_next;

    logic                st1_valid_reg;
    logic                st1_pix_reg;
    logic                st1_rd_ok_reg;
    logic [COL_W-1:0]    st1_col_reg;
    logic [7:0]          st1_px_reg;
    win_col_t            st1_ctl_reg;
    logic [15:0]         rdata_reg;
    logic [15:0]         line_mem [MAX_WIDTH];

    logic                accept, is_pix, push1, ready_px, emit_now, rd_ok;
    logic [HEIGHT_W-1:0] cur_row;
    logic [COL_W-1:0]    cur_col;
    logic                in_col_end, in_row_end, out_col_end, out_row_end, last_now;
    logic [COL_W-1:0]    rd_addr;
    win_col_t            ctl;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size after clamping.
    always_comb begin
        if (EW_W'(width_reg) < EW_W'(2)) begin
            eff_w = EW_W'(2);
        end else if (EW_W'(width_reg) > EW_W'(MAX_WIDTH)) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = EW_W'(width_reg);
        end
        eff_h = (height_reg < HEIGHT_W'(2)) ? HEIGHT_W'(2) : height_reg;
    end

    // One stage in flight plus the queue fill must leave a free slot.
    assign s_tready = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(st1_valid_reg))
                      < (QCNT_W + 1)'(QDEPTH);

    // Classification of the request and the position bookkeeping.
    always_comb begin
        accept   = s_tvalid && s_tready;
        is_pix   = (s_tuser == MODE_PIXEL);
        push1    = accept && (is_pix || draining_reg);
        cur_row  = (is_pix && draining_reg) ? '0 : out_row_reg;
        cur_col  = (is_pix && draining_reg) ? '0 : out_col_reg;
        ready_px = (in_row_reg >= HEIGHT_W'(2)) ||
                   ((in_row_reg == HEIGHT_W'(1)) && (in_col_reg != '0));
        emit_now = is_pix ? ready_px : draining_reg;
        rd_ok    = drain_col_reg < eff_w;

        in_col_end  = ((EW_W + 1)'(in_col_reg) + (EW_W + 1)'(1)) >= (EW_W + 1)'(eff_w);
        in_row_end  = ((HEIGHT_W + 1)'(in_row_reg) + (HEIGHT_W + 1)'(1))
                      >= (HEIGHT_W + 1)'(eff_h);
        out_col_end = ((EW_W + 1)'(cur_col) + (EW_W + 1)'(1)) >= (EW_W + 1)'(eff_w);
        out_row_end = ((HEIGHT_W + 1)'(cur_row) + (HEIGHT_W + 1)'(1))
                      >= (HEIGHT_W + 1)'(eff_h);
        last_now    = out_row_end && out_col_end;

        ctl          = '0;
        ctl.emit     = emit_now;
        ctl.top_ok   = (cur_row != '0);
        ctl.bot_ok   = !out_row_end;
        ctl.left_ok  = (cur_col != '0);
        ctl.right_ok = !out_col_end;
        ctl.last     = last_now;

        rd_addr = is_pix ? in_col_reg : drain_col_reg[COL_W-1:0];

        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        draining_next  = draining_reg;
        drain_col_next = drain_col_reg;

        if (push1) begin
            if (is_pix) begin
                draining_next = 1'b0;
                out_row_next  = cur_row;
                out_col_next  = cur_col;
                if (in_col_end) begin
                    in_col_next = '0;
                    in_row_next = in_row_end ? '0 : in_row_reg + HEIGHT_W'(1);
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end else if (drain_col_reg < EW_W'(MAX_WIDTH)) begin
                drain_col_next = drain_col_reg + EW_W'(1);
            end
            if (emit_now) begin
                if (last_now) begin
                    out_row_next = '0;
                    out_col_next = '0;
                end else if (out_col_end) begin
                    out_col_next = '0;
                    out_row_next = cur_row + HEIGHT_W'(1);
                end else begin
                    out_col_next = cur_col + COL_W'(1);
                end
                if (!is_pix && last_now) begin
                    draining_next = 1'b0;
                end
            end
            if (is_pix && in_col_end && in_row_end && !(emit_now && last_now)) begin
                draining_next  = 1'b1;
                drain_col_next = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            draining_reg  <= 1'b0;
            drain_col_reg <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            draining_reg  <= draining_next;
            drain_col_reg <= drain_col_next;
            st1_valid_reg <= push1;
        end
    end

    // Fetch stage payload.
    always_ff @(posedge aclk) begin
        if (push1) begin
            st1_pix_reg   <= is_pix;
            st1_rd_ok_reg <= rd_ok;
            st1_col_reg   <= in_col_reg;
            st1_px_reg    <= s_tdata;
            st1_ctl_reg   <= ctl;
        end
    end

    // Line store: each word holds the two previous rows of one column.
    always_ff @(posedge aclk) begin
        if (st1_valid_reg && st1_pix_reg) begin
            line_mem[st1_col_reg] <= {rdata_reg[7:0], st1_px_reg};
        end
        if (push1) begin
            rdata_reg <= line_mem[rd_addr];
        end
    end

    // Build the window column for the queue.
    always_comb begin
        q_push  = st1_valid_reg;
        q_entry = st1_ctl_reg;
        if (st1_pix_reg) begin
            q_entry.top = rdata_reg[15:8];
            q_entry.mid = rdata_reg[7:0];
            q_entry.bot = st1_px_reg;
        end else begin
            q_entry.top = st1_rd_ok_reg ? rdata_reg[15:8] : 8'd0;
            q_entry.mid = st1_rd_ok_reg ? rdata_reg[7:0] : 8'd0;
            q_entry.bot = 8'd0;
        end
    end

endmodule

>>> design/bb3_queue.sv
// Short queue of window columns between the front end and the filter.
module bb3_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  bb3_pkg::win_col_t          push_entry,
    input  logic                       pop,
    output logic                       not_empty,
    output bb3_pkg::win_col_t          head,
    output logic [bb3_pkg::QCNT_W-1:0] count
);
    import bb3_pkg::*;

    win_col_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Storage writes.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

>>> design/bb3_back.sv
// Back end: 3x3 window, clipped sum and mean, and the result register.
module bb3_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  bb3_pkg::win_col_t q_head,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);
    import bb3_pkg::*;

    logic [7:0]       win_reg [9];
    logic             a_valid_reg;
    win_col_t         a_ctl_reg;
    logic             b_valid_reg;
    logic [SUM_W-1:0] b_sum_reg;
    div_sel_t         b_div_reg;
    logic             b_last_reg;
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             m_last_reg;

    logic             en;
    logic [SUM_W-1:0] sum;
    div_sel_t         div_sel;
    logic             row_clip, col_clip;
    logic [25:0]      prod;
    logic [7:0]       quot;

    assign en    = !m_valid_reg || m_tready;
    assign q_pop = q_valid && en;

    // Window shift: a new column enters on the right.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= 8'd0;
            end
        end else if (q_pop) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= q_head.top;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= q_head.mid;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= q_head.bot;
        end
    end

    // Masked sum of the cells inside the image.
    always_comb begin
        sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r != 0 || a_ctl_reg.top_ok) && (r != 2 || a_ctl_reg.bot_ok) &&
                    (c != 0 || a_ctl_reg.left_ok) && (c != 2 || a_ctl_reg.right_ok)) begin
                    sum = sum + SUM_W'(win_reg[r * 3 + c]);
                end
            end
        end
        row_clip = !a_ctl_reg.top_ok || !a_ctl_reg.bot_ok;
        col_clip = !a_ctl_reg.left_ok || !a_ctl_reg.right_ok;
        if (row_clip && col_clip) begin
            div_sel = DIV4;
        end else if (row_clip || col_clip) begin
            div_sel = DIV6;
        end else begin
            div_sel = DIV9;
        end
    end

    // Division by reciprocal multiply; exact over the reachable sums.
    always_comb begin
        case (b_div_reg)
            DIV4:    prod = 26'(b_sum_reg) << 14;
            DIV6:    prod = 26'(b_sum_reg) * 26'(RECIP6);
            DIV9:    prod = 26'(b_sum_reg) * 26'(RECIP9);
            default: prod = '0;
        endcase
        quot = prod[23:16];
    end

    // Pipeline valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= q_pop && q_head.emit;
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (q_pop) begin
                a_ctl_reg <= q_head;
            end
            b_sum_reg  <= sum;
            b_div_reg  <= div_sel;
            b_last_reg <= a_ctl_reg.last;
            m_data_reg <= quot;
            m_last_reg <= b_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> design/box_blur_3x3_stream_unit.sv
// A request passes the fetch stage, 4-entry column queue, window, sum and result
// registers. Throughput: one request per cycle while s_tready is high; the output
// pipeline and queue absorb stalls; the line store is read and written once per cycle.
// Reset: synchronous active-low aresetn clears counters, window and queue and
// loads width 640 and height 480; the line store is not cleared.
module box_blur_3x3_stream_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] pixel_in
    input  logic        s_tuser,  // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [7:0] pixel_out
    output logic        m_tlast
);
    import bb3_pkg::*;
    `include "assert_macros.svh"

    logic              q_push, q_pop, q_not_empty;
    win_col_t          q_in, q_head;
    logic [QCNT_W-1:0] q_count;

    // Front end: classification, positions and line store.
    bb3_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    // Column queue.
    bb3_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head),
        .count      (q_count)
    );

    // Filter back end.
    bb3_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The queue never overfills, and a full queue blocks new requests.
    `ASSERT_ALWAYS(a_queue_bound, aclk, aresetn, q_count <= QCNT_W'(QDEPTH))
    `ASSERT_IMPLIES(a_full_blocks, aclk, aresetn, q_count == QCNT_W'(QDEPTH), !s_tready)

endmodule
